/* sv/crs_pkg.sv */
// Shared constants and types for the Catmull-Rom spline evaluator.
package crs_pkg;

    // Default value width and parameter fraction bits.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    // Width of one accumulator slice fed to a partial-product multiplier.
    localparam int CHUNK_W = 32;

    // What an item asks for: position or a derivative with respect to t.
    typedef enum logic [1:0] {
        KIND_POS  = 2'd0,
        KIND_VEL  = 2'd1,
        KIND_ACC  = 2'd2,
        KIND_JERK = 2'd3
    } kind_t;

endpackage

/* sv/crs_horner_step.sv */
// One Horner step acc * t + coef * 2^shift, as two pipeline stages.
module crs_horner_step #(
    parameter int ACC_W      = crs_pkg::VALUE_WIDTH_DEF + 6,
    parameter int T_W        = crs_pkg::T_FRAC_BITS_DEF + 1,
    parameter int COEF_W     = crs_pkg::VALUE_WIDTH_DEF + 6,
    parameter int COEF_SHIFT = crs_pkg::T_FRAC_BITS_DEF,
    parameter int PASS_W     = crs_pkg::T_FRAC_BITS_DEF + 1,
    parameter int SUM_W      = crs_pkg::VALUE_WIDTH_DEF + crs_pkg::T_FRAC_BITS_DEF + 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // upstream side
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic signed [ACC_W-1:0]  acc_i,
    input  logic signed [COEF_W-1:0] coef_i,
    input  logic [PASS_W-1:0]        pass_i,   // t in the low T_W bits, then carried data
    // downstream side
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output logic signed [SUM_W-1:0]  acc_o,
    output logic [PASS_W-1:0]        pass_o
);
    import crs_pkg::*;

    localparam int NCH       = (ACC_W + CHUNK_W - 1) / CHUNK_W;
    localparam int LOW_N     = NCH - 1;
    localparam int LOW_DEPTH = (LOW_N > 0) ? LOW_N : 1;
    localparam int TOP_LSB   = CHUNK_W * LOW_N;
    localparam int TOP_W     = ACC_W - TOP_LSB;
    localparam int PP_W      = CHUNK_W + T_W;
    localparam int PPT_W     = TOP_W + T_W + 1;

    // stage A: partial products
    logic                     a_valid_reg;
    logic                     a_ready;
    logic [PP_W-1:0]          pp_lo_next [LOW_DEPTH];
    logic [PP_W-1:0]          pp_lo_reg  [LOW_DEPTH];
    logic signed [PPT_W-1:0]  pp_top_next;
    logic signed [PPT_W-1:0]  pp_top_reg;
    logic signed [COEF_W-1:0] a_coef_reg;
    logic [PASS_W-1:0]        a_pass_reg;

    // stage B: summed accumulator
    logic                     b_valid_reg;
    logic                     b_ready;
    logic [SUM_W-1:0]         even_sum;
    logic [SUM_W-1:0]         odd_sum;
    logic [SUM_W-1:0]         top_term;
    logic [SUM_W-1:0]         coef_term;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [PASS_W-1:0]        b_pass_reg;

    logic [T_W-1:0]           t_u;
    logic signed [T_W:0]      t_s;
    logic signed [TOP_W-1:0]  top_s;

    // Hold a stage while the next one is full and stalled.
    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    // Multiply each unsigned slice and the signed top slice by t.
    always_comb begin
        t_u   = pass_i[T_W-1:0];
        t_s   = signed'({1'b0, t_u});
        top_s = acc_i[ACC_W-1:TOP_LSB];
        for (int i = 0; i < LOW_DEPTH; i++) begin
            pp_lo_next[i] = '0;
        end
        for (int i = 0; i < LOW_N; i++) begin
            pp_lo_next[i] = PP_W'(acc_i[i*CHUNK_W +: CHUNK_W]) * PP_W'(t_u);
        end
        pp_top_next = PPT_W'(top_s) * PPT_W'(t_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && up_valid) begin
            pp_lo_reg  <= pp_lo_next;
            pp_top_reg <= pp_top_next;
            a_coef_reg <= coef_i;
            a_pass_reg <= pass_i;
        end
    end

    // Alternate slices never overlap, so two groups are merged by placement.
    always_comb begin
        even_sum = '0;
        odd_sum  = '0;
        for (int i = 0; i < LOW_N; i++) begin
            if (i[0]) begin
                odd_sum[i*CHUNK_W +: PP_W] = pp_lo_reg[i];
            end else begin
                even_sum[i*CHUNK_W +: PP_W] = pp_lo_reg[i];
            end
        end
        top_term  = SUM_W'(pp_top_reg) <<< TOP_LSB;
        coef_term = SUM_W'(a_coef_reg) <<< COEF_SHIFT;
        sum_next  = even_sum + odd_sum + top_term + coef_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            sum_reg    <= sum_next;
            b_pass_reg <= a_pass_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign acc_o    = sum_reg;
    assign pass_o   = b_pass_reg;

endmodule

/* sv/catmull_rom_spline_evaluator.sv */
// Top level of the pipelined uniform Catmull-Rom spline evaluator.
//
//  channel  | direction | tdata                                 | tuser
//  s_axis   | in        | ctrl_a, ctrl_b, ctrl_c, ctrl_d, param_t | kind
//  m_axis   | out       | curve_value                           | saturated
//
// One transaction per clock in and out unless the output is stalled. A result
// passes through the registers in order: coefficient build, coefficient
// select, three Horner steps of two stages each (slice multiply, then sum),
// and round/saturate. Reset clears only the stage valid bits. A stalled stage
// holds its data while earlier stages keep filling empty slots behind it.
module catmull_rom_spline_evaluator #(
    parameter int VALUE_WIDTH = crs_pkg::VALUE_WIDTH_DEF,
    parameter int T_FRAC_BITS = crs_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    // ctrl_a, ctrl_b, ctrl_c, ctrl_d, param_t from bit 0 up, zero padded
    input  logic [((4*VALUE_WIDTH+T_FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic [1:0]                                      s_axis_tuser,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // curve_value from bit 0 up, zero padded
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]                m_axis_tdata,
    // saturated
    output logic [0:0]                                      m_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready
);
    import crs_pkg::*;

    localparam int W          = VALUE_WIDTH;
    localparam int F          = T_FRAC_BITS;
    localparam int T_W        = F + 1;
    localparam int CW         = W + 6;
    localparam int A1         = CW + F + 2;
    localparam int A2         = A1 + F + 2;
    localparam int A3         = A2 + F + 2;
    localparam int R_SH       = 3 * F + 1;
    localparam int R_W        = A3 - R_SH;
    localparam int OUT_DATA_W = ((W + 7) / 8) * 8;
    localparam int P1_W       = 2 * CW + T_W;
    localparam int P2_W       = CW + T_W;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // input fields
    logic signed [W-1:0]  a_in, b_in, c_in, d_in;
    logic signed [CW-1:0] a_x, b_x, c_x, d_x;

    // stage K: segment coefficients
    logic                 k_valid_reg;
    logic                 k_ready;
    logic signed [CW-1:0] k0_next, k1_next, k2_next, k3_next;
    logic signed [CW-1:0] k0_reg, k1_reg, k2_reg, k3_reg;
    kind_t                k_kind_reg;
    logic [T_W-1:0]       k_t_reg;

    // stage C: Horner coefficients per kind
    logic                 c_valid_reg;
    logic                 c_ready;
    logic signed [CW-1:0] k3x3, k3x6, k2x2;
    logic signed [CW-1:0] acc0_next, c1_next, c2_next, c3_sel, c3_next;
    logic signed [CW-1:0] acc0_reg, c1_reg, c2_reg, c3_reg;
    logic [T_W-1:0]       c_t_reg;

    // Horner chain
    logic                 s1_ready, s1_valid;
    logic                 s2_ready, s2_valid;
    logic                 s3_ready, s3_valid;
    logic signed [A1-1:0] acc1;
    logic signed [A2-1:0] acc2;
    logic signed [A3-1:0] acc3;
    logic [P1_W-1:0]      pass1;
    logic [P2_W-1:0]      pass2;

    // output stage
    logic                 out_valid_reg;
    logic                 out_ready;
    logic signed [R_W-1:0] rounded;
    logic [R_W-W:0]       high_bits;
    logic                 fits;
    logic [W-1:0]         value_next;
    logic [W-1:0]         out_value_reg;
    logic                 out_sat_reg;

    // Ready chain from the output register back to the input.
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign c_ready       = !c_valid_reg || s1_ready;
    assign k_ready       = !k_valid_reg || c_ready;
    assign s_axis_tready = k_ready;

    // Build k0..k3 from the four control values.
    always_comb begin
        a_in    = s_axis_tdata[0 +: W];
        b_in    = s_axis_tdata[W +: W];
        c_in    = s_axis_tdata[2*W +: W];
        d_in    = s_axis_tdata[3*W +: W];
        a_x     = CW'(a_in);
        b_x     = CW'(b_in);
        c_x     = CW'(c_in);
        d_x     = CW'(d_in);
        k0_next = b_x <<< 1;
        k1_next = c_x - a_x;
        k2_next = (a_x <<< 1) - ((b_x <<< 2) + b_x) + (c_x <<< 2) - d_x;
        k3_next = ((b_x <<< 1) + b_x) - a_x - ((c_x <<< 1) + c_x) + d_x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (k_ready) begin
            k_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (k_ready && s_axis_tvalid) begin
            k0_reg     <= k0_next;
            k1_reg     <= k1_next;
            k2_reg     <= k2_next;
            k3_reg     <= k3_next;
            k_kind_reg <= kind_t'(s_axis_tuser);
            k_t_reg    <= s_axis_tdata[4*W +: T_W];
        end
    end

    // Scale every kind onto one three-step chain with a common final shift;
    // the rounding half LSB rides in with the last coefficient.
    always_comb begin
        k3x3 = (k3_reg <<< 1) + k3_reg;
        k3x6 = k3x3 <<< 1;
        k2x2 = k2_reg <<< 1;
        unique case (k_kind_reg)
            KIND_POS: begin
                acc0_next = k3_reg;
                c1_next   = k2_reg;
                c2_next   = k1_reg;
                c3_sel    = k0_reg;
            end
            KIND_VEL: begin
                acc0_next = '0;
                c1_next   = k3x3;
                c2_next   = k2x2;
                c3_sel    = k1_reg;
            end
            KIND_ACC: begin
                acc0_next = '0;
                c1_next   = '0;
                c2_next   = k3x6;
                c3_sel    = k2x2;
            end
            KIND_JERK: begin
                acc0_next = '0;
                c1_next   = '0;
                c2_next   = '0;
                c3_sel    = k3x6;
            end
            default: begin
                acc0_next = '0;
                c1_next   = '0;
                c2_next   = '0;
                c3_sel    = '0;
            end
        endcase
        c3_next = c3_sel + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && k_valid_reg) begin
            acc0_reg <= acc0_next;
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            c3_reg   <= c3_next;
            c_t_reg  <= k_t_reg;
        end
    end

    // Horner step 1: acc0 t + c1 2^F
    crs_horner_step #(
        .ACC_W      (CW),
        .T_W        (T_W),
        .COEF_W     (CW),
        .COEF_SHIFT (F),
        .PASS_W     (P1_W),
        .SUM_W      (A1)
    ) u_step1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (c_valid_reg),
        .up_ready (s1_ready),
        .acc_i    (acc0_reg),
        .coef_i   (c1_reg),
        .pass_i   ({c3_reg, c2_reg, c_t_reg}),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .acc_o    (acc1),
        .pass_o   (pass1)
    );

    // Horner step 2: add c2 2^(2F)
    crs_horner_step #(
        .ACC_W      (A1),
        .T_W        (T_W),
        .COEF_W     (CW),
        .COEF_SHIFT (2 * F),
        .PASS_W     (P2_W),
        .SUM_W      (A2)
    ) u_step2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .acc_i    (acc1),
        .coef_i   (pass1[T_W +: CW]),
        .pass_i   ({pass1[T_W+CW +: CW], pass1[T_W-1:0]}),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .acc_o    (acc2),
        .pass_o   (pass2)
    );

    // Horner step 3: add c3 2^(3F)
    crs_horner_step #(
        .ACC_W      (A2),
        .T_W        (T_W),
        .COEF_W     (CW),
        .COEF_SHIFT (3 * F),
        .PASS_W     (T_W),
        .SUM_W      (A3)
    ) u_step3 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s2_valid),
        .up_ready (s3_ready),
        .acc_i    (acc2),
        .coef_i   (pass2[T_W +: CW]),
        .pass_i   (pass2[T_W-1:0]),
        .dn_valid (s3_valid),
        .dn_ready (out_ready),
        .acc_o    (acc3),
        .pass_o   ()
    );

    // Drop the fraction bits and clamp to the output range.
    always_comb begin
        rounded   = acc3[A3-1:R_SH];
        high_bits = rounded[R_W-1:W-1];
        fits      = (&high_bits) || !(|high_bits);
        if (fits) begin
            value_next = rounded[W-1:0];
        end else if (rounded[R_W-1]) begin
            value_next = SAT_MIN;
        end else begin
            value_next = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s3_valid) begin
            out_value_reg <= value_next;
            out_sat_reg   <= !fits;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_value_reg);
    assign m_axis_tuser  = out_sat_reg;

    // An accepted transaction always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> k_valid_reg)
        else $error("accepted transaction missing from first stage");

    // With the output register empty the whole chain must be able to move.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    // A saturated result carries one of the two range limits.
    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            (out_value_reg == SAT_MAX) || (out_value_reg == SAT_MIN))
        else $error("saturated flag without a clamped value");

endmodule

/* tb/catmull_rom_spline_evaluator_tb.sv */
// Self-checking testbench for the Catmull-Rom spline evaluator stream pipeline.
`timescale 1ns / 100ps

module catmull_rom_spline_evaluator_tb;
    import crs_pkg::*;

    localparam int VW         = 32;
    localparam int TF         = 16;
    localparam int S_TDATA_W  = ((4*VW+TF+1+7)/8)*8;
    localparam int M_TDATA_W  = ((VW+7)/8)*8;
    localparam int RAND_ITEMS = 140;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [VW-1:0] CTRL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] CTRL_MIN = 32'sh8000_0000;
    localparam logic [TF:0]          T_ONE    = 17'h1_0000;
    localparam logic [TF:0]          T_TOP    = 17'h1_FFFF;

    // One input transaction and one result transaction
    typedef struct {
        kind_t                kind;
        logic signed [VW-1:0] ctrl_a;
        logic signed [VW-1:0] ctrl_b;
        logic signed [VW-1:0] ctrl_c;
        logic signed [VW-1:0] ctrl_d;
        logic [TF:0]          param_t;
    } segment_req_t;

    typedef struct {
        logic [VW-1:0] curve_value;
        logic          saturated;
    } curve_sample_t;

    // Predicts each curve sample and checks results in arrival order
    class spline_scoreboard;
        curve_sample_t expected_samples[$];
        int            errors;
        int            checked;
        int            sat_seen;

        function curve_sample_t eval_segment(segment_req_t it);
            logic signed [127:0] a, b, c, d, t, k0, k1, k2, k3, acc;
            logic signed [127:0] lim_hi, lim_lo;
            int unsigned         shift;
            curve_sample_t       r;
            a = it.ctrl_a;
            b = it.ctrl_b;
            c = it.ctrl_c;
            d = it.ctrl_d;
            t = {111'd0, it.param_t};
            lim_hi = 128'sd2147483647;
            lim_lo = -128'sd2147483648;
            k0 = 2 * b;
            k1 = c - a;
            k2 = 2 * a - 5 * b + 4 * c - d;
            k3 = 3 * b - a - 3 * c + d;
            // Exact Horner evaluation, scaled by powers of the t fraction
            case (it.kind)
                KIND_POS: begin
                    acc = ((k3 * t + (k2 <<< TF)) * t + (k1 <<< (2*TF))) * t + (k0 <<< (3*TF));
                    shift = 3 * TF + 1;
                end
                KIND_VEL: begin
                    acc = (3 * k3 * t + ((2 * k2) <<< TF)) * t + (k1 <<< (2*TF));
                    shift = 2 * TF + 1;
                end
                KIND_ACC: begin
                    acc = 3 * k3 * t + (k2 <<< TF);
                    shift = TF;
                end
                default: begin
                    acc = 3 * k3;
                    shift = 0;
                end
            endcase
            // Round half up, then clamp to the signed output range
            if (shift != 0)
                acc = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
            if (acc > lim_hi) begin
                r.curve_value = 32'h7FFF_FFFF;
                r.saturated   = 1'b1;
            end else if (acc < lim_lo) begin
                r.curve_value = 32'h8000_0000;
                r.saturated   = 1'b1;
            end else begin
                r.curve_value = acc[VW-1:0];
                r.saturated   = 1'b0;
            end
            return r;
        endfunction

        function void note_input(segment_req_t it);
            expected_samples.push_back(eval_segment(it));
        endfunction

        function void check_result(logic [VW-1:0] value, logic sat);
            curve_sample_t exp_s;
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result value=%h sat=%b", $time, value, sat);
                errors++;
                return;
            end
            exp_s = expected_samples.pop_front();
            checked++;
            if (sat)
                sat_seen++;
            if (value !== exp_s.curve_value) begin
                $display("%0t: curve_value expected %h actual %h",
                         $time, exp_s.curve_value, value);
                errors++;
            end
            if (sat !== exp_s.saturated) begin
                $display("%0t: saturated expected %b actual %b",
                         $time, exp_s.saturated, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    spline_scoreboard sb = new;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    bit  hold_off       = 1'b0;
    int  cycle_count    = 0;
    int  sent_count     = 0;
    int  kind_count[4];

    catmull_rom_spline_evaluator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Free-running clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run timeout
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Long output hold-off, requested once by the stimulus
    initial begin : output_hold
        wait (hold_req);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Check each result transaction, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[VW-1:0], m_axis_tuser[0]);
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic segment_req_t make_item(kind_t k, logic signed [VW-1:0] a,
                                               logic signed [VW-1:0] b,
                                               logic signed [VW-1:0] c,
                                               logic signed [VW-1:0] d, logic [TF:0] t);
        segment_req_t it;
        it.kind    = k;
        it.ctrl_a  = a;
        it.ctrl_b  = b;
        it.ctrl_c  = c;
        it.ctrl_d  = d;
        it.param_t = t;
        return it;
    endfunction

    // Control value: full range, small, near either extreme, or near zero
    function automatic logic signed [VW-1:0] rand_ctrl();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 2097152)) - 1048576;
            7:          return CTRL_MAX - $urandom_range(0, 15);
            8:          return CTRL_MIN + $urandom_range(0, 15);
            default:    return int'($urandom_range(0, 2)) - 1;
        endcase
    endfunction

    // Curve parameter: mostly inside the segment, some extrapolation and corners
    function automatic logic [TF:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return (TF+1)'($urandom_range(0, 131071));
            1: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return T_ONE;
                    2:       return 17'd1;
                    default: return T_TOP;
                endcase
            end
            default: return (TF+1)'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offer one transaction after a random idle gap and wait for acceptance
    task automatic send_item(segment_req_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {{(S_TDATA_W-4*VW-TF-1){1'b0}}, it.param_t,
                          it.ctrl_d, it.ctrl_c, it.ctrl_b, it.ctrl_a};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(it);
        sent_count++;
        kind_count[it.kind]++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_item(make_item(kind_t'($urandom_range(0, 3)), rand_ctrl(), rand_ctrl(),
                                rand_ctrl(), rand_ctrl(), rand_param()));
    endtask

    initial begin : stimulus
        int directed_count;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of every kind, extrapolation and rounding ties
        for (int k = 0; k < 4; k++) begin
            send_item(make_item(kind_t'(k), CTRL_MIN, CTRL_MAX, CTRL_MIN, CTRL_MAX, T_ONE));
            send_item(make_item(kind_t'(k), CTRL_MAX, CTRL_MIN, CTRL_MAX, CTRL_MIN, T_TOP));
            send_item(make_item(kind_t'(k), CTRL_MIN, CTRL_MIN, CTRL_MIN, CTRL_MIN, '0));
            send_item(make_item(kind_t'(k), 32'sh0, 32'sh1_0000, 32'sh2_0000, 32'sh3_0000,
                                17'h0_8000));
        end
        send_item(make_item(KIND_POS, CTRL_MAX, CTRL_MAX, CTRL_MAX, CTRL_MAX, T_TOP));
        send_item(make_item(KIND_POS, 32'sh0, 32'sh0, 32'sh0, 32'sh0, T_TOP));
        // Exact half LSB, positive and negative: both round toward plus infinity
        send_item(make_item(KIND_ACC, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 17'h0_8000));
        send_item(make_item(KIND_ACC, 32'sh0, 32'sh0, 32'sh0, -32'sh1, 17'h0_8000));
        send_item(make_item(KIND_VEL, 32'sh5, -32'sh3, 32'sh7, -32'sh1, 17'd1));
        directed_count = sent_count;

        // Random phases with different handshake pressure
        send_random(RAND_ITEMS);
        send_idle_pct = 81;
        send_random(RAND_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct <= 81;
        send_random(RAND_ITEMS);
        send_idle_pct  = 34;
        recv_stall_pct <= 34;
        send_random(RAND_ITEMS);

        // Back-pressure: hold the output while input keeps coming
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_req = 1'b1;
        send_random(RAND_ITEMS);
        s_axis_tvalid <= 1'b0;

        // Drain and let the pipeline settle
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d transactions (%0d directed): %0d position, %0d first,",
                 sent_count, directed_count, kind_count[0], kind_count[1]);
        $display("  %0d second, %0d third", kind_count[2], kind_count[3]);
        $display("Checked %0d results, %0d clamped, across idle/stall phases and a %0d-cycle hold",
                 sb.checked, sb.sat_seen, HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
